/* src/rgbp_pkg.sv */
`default_nettype none

package rgbp_pkg;

    localparam int CHAR_W = 8;
    localparam int CHAN_W = 8;
    localparam int SLOT_W = 4;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_NL   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;

    // slot codes: 0..2 red, 3..5 green, 6..8 blue, 9 all fields done
    localparam logic [SLOT_W-1:0] SLOT_RED   = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_GREEN = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_BLUE  = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_DONE  = 4'd9;

    typedef struct packed {
        logic              fire;
        logic [CHAR_W-1:0] ch;
    } t_step;

    // red in the lowest bits when packed
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    function automatic logic [CHAN_W-1:0] mac_sat(input logic [CHAN_W-1:0] acc,
                                                  input logic [DIGIT_W-1:0] d);
        logic [11:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, d};
        return (v > 12'd255) ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/rgbp_parse.sv */
`default_nettype none

module rgbp_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rgbp_pkg::t_step i_step,
    output logic               o_is_nl,
    output rgbp_pkg::t_rgb     o_rgb
);
    import rgbp_pkg::*;

    logic [CHAN_W-1:0] r_red, r_green, r_blue;
    logic [CHAN_W-1:0] n_red, n_green, n_blue;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_sep_seen, n_sep_seen;

    logic [SLOT_W-1:0]  pos;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;

    always_comb begin
        pos      = (r_slot > SLOT_DONE) ? SLOT_DONE : r_slot;
        o_is_nl  = (i_step.ch == CHAR_NL);
        is_digit = (i_step.ch >= CHAR_ZERO) && (i_step.ch <= CHAR_NINE);
        digit    = i_step.ch[DIGIT_W-1:0];

        n_red      = r_red;
        n_green    = r_green;
        n_blue     = r_blue;
        n_slot     = pos;
        n_sep_seen = r_sep_seen;

        if (o_is_nl) begin
            n_red      = '0;
            n_green    = '0;
            n_blue     = '0;
            n_slot     = SLOT_RED;
            n_sep_seen = 1'b0;
        end else if (is_digit) begin
            n_sep_seen = 1'b0;
            if (pos < SLOT_DONE) begin
                if (pos < SLOT_GREEN) begin
                    n_red = mac_sat(r_red, digit);
                end else if (pos < SLOT_BLUE) begin
                    n_green = mac_sat(r_green, digit);
                end else begin
                    n_blue = mac_sat(r_blue, digit);
                end
                // advance only up to the third slot of the field
                if (pos != 4'd2 && pos != 4'd5 && pos != 4'd8) begin
                    n_slot = pos + 4'd1;
                end
            end
        end else if (!r_sep_seen) begin
            if (pos < SLOT_GREEN) begin
                n_slot = SLOT_GREEN;
            end else if (pos < SLOT_BLUE) begin
                n_slot = SLOT_BLUE;
            end else begin
                n_slot = SLOT_DONE;
            end
            n_sep_seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red      <= '0;
            r_green    <= '0;
            r_blue     <= '0;
            r_slot     <= SLOT_RED;
            r_sep_seen <= 1'b0;
        end else if (i_step.fire) begin
            r_red      <= n_red;
            r_green    <= n_green;
            r_blue     <= n_blue;
            r_slot     <= n_slot;
            r_sep_seen <= n_sep_seen;
        end
    end

    assign o_rgb = '{blue: r_blue, green: r_green, red: r_red};

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_DONE)
        else $error("slot position out of range");

    a_sep_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sep_seen |-> (r_slot == SLOT_GREEN || r_slot == SLOT_BLUE || r_slot == SLOT_DONE))
        else $error("separator flag set off a field boundary");

    a_nl_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.fire && o_is_nl |=> r_slot == SLOT_RED && !r_sep_seen
            && r_red == '0 && r_green == '0 && r_blue == '0)
        else $error("newline did not clear the state");

endmodule

`default_nettype wire

/* src/rgb_decimal_triple_parser.sv */
// channel   dir  tdata fields (low bit up)             tuser  tlast
// s_axis    in   char_in[7:0]                          -      -
// m_axis    out  red[7:0], green[15:8], blue[23:16]    -      -
//
// one item per cycle while no newline waits on a stalled output; a result is registered
// once its newline leaves the input register, which feeds the parse update;
// a newline loads the output register, other characters give no result.
// a newline waits in the input register only while an untaken result stalls the output.
// synchronous active-low reset clears the accumulators, slot position and both valids.
`default_nettype none

module rgb_decimal_triple_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // char_in[7:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import rgbp_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_out_valid;
    t_rgb              r_out_data;

    t_step  step;
    t_rgb   acc;
    logic   is_nl;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign step.ch    = r_in_char;
    // a newline needs a free output slot, anything else moves on at once
    assign step.fire  = r_in_valid && (!is_nl || out_free);

    assign o_s_axis_tready = !r_in_valid || step.fire;

    rgbp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_is_nl (is_nl),
        .o_rgb   (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (step.fire && is_nl) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
        end
        if (step.fire && is_nl) begin
            r_out_data <= acc;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

/* sim/rgb_decimal_triple_parser_tb.sv */
`default_nettype none

module rgb_decimal_triple_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbp_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_TAIL   = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 21;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        bit                typed;
        t_rgb              rgb;
    } t_char_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata = 8'h00;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;

    rgb_decimal_triple_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser shadow state
    logic [CHAN_W-1:0] red_sum;
    logic [CHAN_W-1:0] green_sum;
    logic [CHAN_W-1:0] blue_sum;
    logic [SLOT_W-1:0] slot_pos;
    bit                sep_seen;

    t_char_item char_stream[$];
    t_rgb       rgb_pending[$];
    int         accepted = 0;
    int         rgb_checked = 0;
    int         errors = 0;
    int         cycles = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    bit         in_taken = 1'b0;
    bit         hold_off = 1'b0;
    bit         quiet = 1'b0;

    // newline, saturation, leading separator, separator runs, digits after blue
    t_char_item directed_rows [N_DIRECTED] = '{
        '{ch: CHAR_NL, typed: 1'b1, rgb: '{blue: 8'd0, green: 8'd0, red: 8'd0}},
        '{ch: 8'h39, typed: 1'b0, rgb: '0},
        '{ch: 8'h39, typed: 1'b0, rgb: '0},
        '{ch: 8'h39, typed: 1'b0, rgb: '0},
        '{ch: 8'h39, typed: 1'b0, rgb: '0},
        '{ch: 8'h2C, typed: 1'b0, rgb: '0},
        '{ch: 8'h32, typed: 1'b0, rgb: '0},
        '{ch: 8'h35, typed: 1'b0, rgb: '0},
        '{ch: 8'h35, typed: 1'b0, rgb: '0},
        '{ch: 8'h20, typed: 1'b0, rgb: '0},
        '{ch: CHAR_ZERO, typed: 1'b0, rgb: '0},
        '{ch: CHAR_NL, typed: 1'b1, rgb: '{blue: 8'd0, green: 8'd255, red: 8'd255}},
        '{ch: 8'hFF, typed: 1'b0, rgb: '0},
        '{ch: 8'h00, typed: 1'b0, rgb: '0},
        '{ch: 8'h37, typed: 1'b0, rgb: '0},
        '{ch: 8'h80, typed: 1'b0, rgb: '0},
        '{ch: 8'h31, typed: 1'b0, rgb: '0},
        '{ch: 8'h7F, typed: 1'b0, rgb: '0},
        '{ch: 8'h35, typed: 1'b0, rgb: '0},
        '{ch: 8'h7F, typed: 1'b0, rgb: '0},
        '{ch: CHAR_NL, typed: 1'b1, rgb: '{blue: 8'd1, green: 8'd7, red: 8'd0}}
    };

    function automatic logic [CHAN_W-1:0] times_ten_plus(input logic [CHAN_W-1:0] acc,
                                                         input int digit);
        int v;
        v = int'(acc) * 10 + digit;
        return (v > 255) ? CHAN_MAX : CHAN_W'(v);
    endfunction

    function automatic bit predict_char(input logic [CHAR_W-1:0] ch, output t_rgb rgb);
        int pos;
        int digit;
        int nxt;
        pos = (slot_pos > SLOT_DONE) ? int'(SLOT_DONE) : int'(slot_pos);
        rgb = '0;
        if (ch == CHAR_NL) begin
            rgb.red = red_sum;
            rgb.green = green_sum;
            rgb.blue = blue_sum;
            red_sum = '0;
            green_sum = '0;
            blue_sum = '0;
            slot_pos = '0;
            sep_seen = 1'b0;
            return 1'b1;
        end
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            digit = int'(ch - CHAR_ZERO);
            sep_seen = 1'b0;
            if (pos < int'(SLOT_DONE)) begin
                if (pos < int'(SLOT_GREEN))
                    red_sum = times_ten_plus(red_sum, digit);
                else if (pos < int'(SLOT_BLUE))
                    green_sum = times_ten_plus(green_sum, digit);
                else
                    blue_sum = times_ten_plus(blue_sum, digit);
                // slot stops at the third digit of a field
                if (pos % 3 < 2)
                    pos = pos + 1;
            end
            slot_pos = SLOT_W'(pos);
        end else if (!sep_seen) begin
            nxt = (pos / 3 + 1) * 3;
            if (nxt > int'(SLOT_DONE))
                nxt = int'(SLOT_DONE);
            slot_pos = SLOT_W'(nxt);
            sep_seen = 1'b1;
        end else begin
            slot_pos = SLOT_W'(pos);
        end
        return 1'b0;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_separator();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(0, 255));
        while (c == CHAR_NL || (c >= CHAR_ZERO && c <= CHAR_NINE));
        return c;
    endfunction

    task automatic add_char(input logic [CHAR_W-1:0] ch);
        t_char_item it;
        it.ch = ch;
        it.typed = 1'b0;
        it.rgb = '0;
        char_stream.push_back(it);
    endtask

    task automatic add_field();
        int ndig;
        int v;
        if ($urandom_range(0, 5) == 0) begin
            // three digits around the saturation point
            v = $urandom_range(245, 265);
            add_char(CHAR_ZERO + CHAR_W'(v / 100));
            add_char(CHAR_ZERO + CHAR_W'((v / 10) % 10));
            add_char(CHAR_ZERO + CHAR_W'(v % 10));
        end else begin
            ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
            repeat (ndig) add_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
    endtask

    task automatic add_line();
        int kind;
        int nfields;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise, newlines included
            repeat ($urandom_range(1, 8)) add_char(CHAR_W'($urandom_range(0, 255)));
        end else begin
            nfields = $urandom_range(1, 5);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 2)) add_char(pick_separator());
            for (int f = 0; f < nfields; f++) begin
                if (f > 0)
                    repeat ($urandom_range(1, 3)) add_char(pick_separator());
                add_field();
            end
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) add_char(pick_separator());
            // broken lines run on into the next one
            if (kind != 1)
                add_char(CHAR_NL);
        end
    endtask

    initial begin
        red_sum = '0;
        green_sum = '0;
        blue_sum = '0;
        slot_pos = '0;
        sep_seen = 1'b0;
        foreach (directed_rows[i])
            char_stream.push_back(directed_rows[i]);
        while (char_stream.size() < N_DIRECTED + RANDOM_ITEMS)
            add_line();
        add_char(CHAR_NL);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted == char_stream.size());
        wait (rgb_pending.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("sent %0d characters (%0d directed), checked %0d rgb triples",
                 char_stream.size(), N_DIRECTED, rgb_checked);
        $display("errors: %0d", errors);
        if (errors == 0)
            $display("rgb_decimal_triple_parser: match");
        else
            $display("rgb_decimal_triple_parser: mismatch");
        $finish;
    end

    // long output stall while characters keep coming
    initial begin
        wait (accepted >= 300);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        t_rgb predicted;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rgb_decimal_triple_parser: mismatch");
            $finish;
        end else if (i_rst_n) begin
            in_taken = i_s_axis_tvalid && o_s_axis_tready;
            if (in_taken) begin
                if (predict_char(char_stream[accepted].ch, predicted))
                    rgb_pending.push_back(char_stream[accepted].typed ?
                                          char_stream[accepted].rgb : predicted);
                accepted++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (rgb_pending.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected rgb item r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue);
                end else begin
                    want = rgb_pending.pop_front();
                    rgb_checked++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        errors++;
                        if (errors <= 10)
                            $display("rgb item %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     rgb_checked, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    // character sender
    always @(negedge i_clk) begin
        quiet = accepted >= char_stream.size() - QUIET_TAIL;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !in_taken) begin
            // item still offered, hold it
        end else if (send_gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap--;
        end else if (accepted < char_stream.size()) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                i_s_axis_tvalid <= 1'b0;
                send_gap = $urandom_range(0, 8);
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= char_stream[accepted].ch;
            end
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            i_m_axis_tready <= 1'b0;
            recv_gap--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_m_axis_tready <= 1'b0;
            recv_gap = $urandom_range(0, 8);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

endmodule

`default_nettype wire
